>>> hw/rtl/sdq_pkg.sv
// shared types and codes for the sorted deque store
package sdq_pkg;

    localparam int DATA_W = 16;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_SORTED     = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4,
        OP_REMOVE     = 3'd5,
        OP_SEARCH     = 3'd6,
        OP_NONE       = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_LOAD = 2'd1,
        CELL_PREV = 2'd2,
        CELL_NEXT = 2'd3
    } cell_mode_t;

    typedef struct packed {
        logic front;
        logic back;
    } cell_flags_t;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_APPLY = 1'b1
    } state_t;

    localparam data_t EMPTY_DATA = -16'sd1;

endpackage

>>> hw/rtl/sdq_cell.sv
// one storage cell of the chain: holds an entry, compares it, shifts with its neighbors
module sdq_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic               clk,
    input  sdq_pkg::cell_mode_t mode,
    input  sdq_pkg::data_t     load_value,
    input  sdq_pkg::data_t     prev_entry,
    input  sdq_pkg::data_t     next_entry,
    input  sdq_pkg::data_t     key,
    input  logic               ins,
    input  logic [CW-1:0]      occ,
    input  logic [CW-1:0]      half,
    output sdq_pkg::data_t     entry,
    output sdq_pkg::cell_flags_t flags,
    output sdq_pkg::data_t     tail
);
    import sdq_pkg::*;

    data_t         entry_reg;
    data_t         entry_next;
    logic          valid;
    logic [CW-1:0] dist_back;
    logic          front_ok;
    logic          back_ok;

    always_comb
    begin
        case (mode)
            CELL_LOAD: entry_next = load_value;
            CELL_PREV: entry_next = prev_entry;
            CELL_NEXT: entry_next = next_entry;
            default:   entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // step index seen from the front is IDX, from the back occ-1-IDX
    assign valid     = CW'(IDX) < occ;
    assign dist_back = occ - CW'(1) - CW'(IDX);
    assign front_ok  = CW'(IDX) <= half;
    assign back_ok   = dist_back <= half;

    always_comb
    begin
        if (ins)
        begin
            flags.front = valid && front_ok && (key <= entry_reg);
            flags.back  = valid && back_ok && (key >= entry_reg);
        end
        else
        begin
            flags.front = valid && front_ok && (key == entry_reg);
            flags.back  = valid && back_ok && (key == entry_reg);
        end
    end

    assign entry = entry_reg;
    assign tail  = (valid && (dist_back == '0)) ? entry_reg : '0;

endmodule

>>> hw/rtl/sdq_pick.sv
// resolves the cell match flags into the position nearest either end
module sdq_pick #(
    parameter int DEPTH = 64
) (
    input  logic [DEPTH-1:0]              front_hits,
    input  logic [DEPTH-1:0]              back_hits,
    input  logic [$clog2(DEPTH+1)-1:0]    occ,
    input  logic [$clog2(DEPTH+1)-1:0]    half,
    input  logic                          ins,
    output logic [$clog2(DEPTH+1)-1:0]    pos,
    output logic                          found
);
    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [DEPTH-1:0] front_first;
    logic [DEPTH-1:0] back_rev;
    logic [DEPTH-1:0] back_first;
    logic [IW-1:0]    front_idx;
    logic [IW-1:0]    back_ridx;
    logic [IW-1:0]    back_idx;
    logic [CW-1:0]    front_key;
    logic [CW-1:0]    back_key;
    logic             front_any;
    logic             back_any;
    logic             use_front;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            back_rev[i] = back_hits[DEPTH-1-i];
        end
    end

    // isolate the lowest set bit
    assign front_first = front_hits & (~front_hits + {{(DEPTH-1){1'b0}}, 1'b1});
    assign back_first  = back_rev & (~back_rev + {{(DEPTH-1){1'b0}}, 1'b1});

    always_comb
    begin
        front_idx = '0;
        back_ridx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (front_first[i])
            begin
                front_idx = front_idx | IW'(i);
            end
            if (back_first[i])
            begin
                back_ridx = back_ridx | IW'(i);
            end
        end
    end

    assign back_idx  = IW'(DEPTH-1) - back_ridx;
    assign front_any = |front_hits;
    assign back_any  = |back_hits;
    assign front_key = CW'(front_idx);
    assign back_key  = occ - CW'(1) - CW'(back_idx);

    // front wins when both sides hit at the same step
    assign use_front = front_any && (!back_any || (front_key <= back_key));
    assign found     = front_any || back_any;

    always_comb
    begin
        if (use_front)
        begin
            pos = front_key;
        end
        else if (back_any)
        begin
            pos = ins ? (CW'(back_idx) + CW'(1)) : CW'(back_idx);
        end
        else if (occ == '0)
        begin
            pos = '0;
        end
        else
        begin
            // scans met in the middle without a hit
            pos = half + CW'(1);
        end
    end

endmodule

>>> hw/rtl/sorted_deque_store_unit.sv
// top level of the sorted deque store: control, cell chain and match resolve
// done and the result are registered from the apply state that the accepting edge enters
// no new item is accepted until the apply cycle ends; busy stays high for the apply cycle
// all cells compare in the accept cycle, the shift happens in the apply cycle
// reset clears occupancy and control; entries stay undefined until written
// the receiver cannot stall, so a result is shown for one cycle only
module sorted_deque_store_unit #(
    parameter int DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    op,
    input  logic signed [15:0]            value,
    output logic                          done,
    output logic signed [15:0]            data_out,
    output logic [1:0]                    status,
    output logic [$clog2(DEPTH+1)-1:0]    count
);
    import sdq_pkg::*;

    localparam int CW = $clog2(DEPTH+1);

    state_t           state_reg;
    state_t           state_next;
    op_t              op_reg;
    data_t            value_reg;
    logic [DEPTH-1:0] front_reg;
    logic [DEPTH-1:0] back_reg;
    data_t            tail_reg;
    logic [CW-1:0]    occ_reg;
    logic [CW-1:0]    occ_next;
    data_t            data_out_reg;
    data_t            data_out_next;
    status_t          status_reg;
    status_t          status_next;
    logic             done_reg;
    logic             done_next;

    logic             accept;
    logic             ins_cmp;
    logic [CW-1:0]    half;
    logic             ins_en;
    logic             rem_en;
    logic [CW-1:0]    ipos;
    logic [CW-1:0]    rpos;
    logic [CW-1:0]    pick_pos;
    logic             pick_found;
    logic [DEPTH-1:0] front_hits;
    logic [DEPTH-1:0] back_hits;
    data_t            tail_any;

    data_t            cell_entry [DEPTH];
    cell_flags_t      cell_flags [DEPTH];
    data_t            cell_tail  [DEPTH];
    cell_mode_t       cell_mode  [DEPTH];

    assign accept  = start && (state_reg == S_IDLE);
    assign busy    = (state_reg != S_IDLE);
    assign ins_cmp = (op == OP_SORTED);
    assign half    = (occ_reg - CW'(1)) >> 1;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            always_comb
            begin
                if (ins_en && (CW'(g) == ipos))
                begin
                    cell_mode[g] = CELL_LOAD;
                end
                else if (ins_en && (CW'(g) > ipos))
                begin
                    cell_mode[g] = CELL_PREV;
                end
                else if (rem_en && (CW'(g) >= rpos))
                begin
                    cell_mode[g] = CELL_NEXT;
                end
                else
                begin
                    cell_mode[g] = CELL_HOLD;
                end
            end

            sdq_cell #(
                .IDX (g),
                .CW  (CW)
            ) u_cell (
                .clk        (clk),
                .mode       (cell_mode[g]),
                .load_value (value_reg),
                .prev_entry (cell_entry[(g == 0) ? 0 : g-1]),
                .next_entry (cell_entry[(g == DEPTH-1) ? g : g+1]),
                .key        (data_t'(value)),
                .ins        (ins_cmp),
                .occ        (occ_reg),
                .half       (half),
                .entry      (cell_entry[g]),
                .flags      (cell_flags[g]),
                .tail       (cell_tail[g])
            );

            assign front_hits[g] = cell_flags[g].front;
            assign back_hits[g]  = cell_flags[g].back;
        end
    endgenerate

    always_comb
    begin
        tail_any = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tail_any = tail_any | cell_tail[i];
        end
    end

    sdq_pick #(
        .DEPTH (DEPTH)
    ) u_pick (
        .front_hits (front_reg),
        .back_hits  (back_reg),
        .occ        (occ_reg),
        .half       (half),
        .ins        (op_reg == OP_SORTED),
        .pos        (pick_pos),
        .found      (pick_found)
    );

    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = accept ? S_APPLY : S_IDLE;
            S_APPLY: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        occ_next      = occ_reg;
        data_out_next = '0;
        status_next   = ST_OK;
        done_next     = 1'b0;
        ins_en        = 1'b0;
        rem_en        = 1'b0;
        ipos          = '0;
        rpos          = '0;
        if (state_reg == S_APPLY)
        begin
            done_next = 1'b1;
            case (op_reg)
                OP_PUSH_FRONT, OP_PUSH_BACK, OP_SORTED:
                begin
                    if (occ_reg == CW'(DEPTH))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ins_en   = 1'b1;
                        occ_next = occ_reg + CW'(1);
                        case (op_reg)
                            OP_PUSH_FRONT: ipos = '0;
                            OP_PUSH_BACK:  ipos = occ_reg;
                            default:       ipos = pick_pos;
                        endcase
                    end
                end
                OP_POP_FRONT, OP_POP_BACK:
                begin
                    if (occ_reg == '0)
                    begin
                        data_out_next = EMPTY_DATA;
                        status_next   = ST_EMPTY;
                    end
                    else
                    begin
                        rem_en   = 1'b1;
                        occ_next = occ_reg - CW'(1);
                        if (op_reg == OP_POP_FRONT)
                        begin
                            data_out_next = cell_entry[0];
                            rpos          = '0;
                        end
                        else
                        begin
                            data_out_next = tail_reg;
                            rpos          = occ_reg - CW'(1);
                        end
                    end
                end
                OP_REMOVE, OP_SEARCH:
                begin
                    if (!pick_found)
                    begin
                        status_next = ST_NOTFOUND;
                    end
                    else if (op_reg == OP_REMOVE)
                    begin
                        rem_en   = 1'b1;
                        rpos     = pick_pos;
                        occ_next = occ_reg - CW'(1);
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            occ_reg    <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    // item operands and match flags captured at accept
    always_ff @(posedge clk)
    begin
        data_out_reg <= data_out_next;
        if (accept)
        begin
            op_reg    <= op_t'(op);
            value_reg <= data_t'(value);
            front_reg <= front_hits;
            back_reg  <= back_hits;
            tail_reg  <= tail_any;
        end
    end

    assign done     = done_reg;
    assign data_out = data_out_reg;
    assign status   = status_reg;
    assign count    = occ_reg;

    a_done_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_APPLY))
        else $error("result strobe without an apply cycle");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("result strobe while busy");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(DEPTH))
        else $error("occupancy above depth");

    a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == $past(occ_reg)) || (occ_reg == $past(occ_reg) + CW'(1)) ||
        (occ_reg + CW'(1) == $past(occ_reg)))
        else $error("occupancy moved by more than one");

    a_occ_only_in_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> (occ_reg == $past(occ_reg)))
        else $error("occupancy changed outside apply");

endmodule
